[rtl/assert_macros.svh]
// Assertion macros used by the top level of the back-off timeout sequencer.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(name, clk, rst_n, prop, msg)
`define ASSERT_NEVER(name, clk, rst_n, cond, msg)
`endif

`endif

[rtl/bts_pkg.sv]
// Types, codes and constants of the back-off timeout sequencer.
// No dependencies; used by every module of the block except bts_ram.
package bts_pkg;

  localparam int TABLE_DEPTH_DEF = 8;
  localparam int DUR_W           = 32;
  localparam int MULT_W          = 16;
  localparam int CNT_W           = 16;
  localparam int LEN_W           = 4;
  localparam int IDX_W           = 3;
  localparam int CFG_AW          = 3;
  localparam int CFG_DW          = 32;
  localparam int OUTQ_DEPTH      = 3;
  localparam int OUTQ_PW         = 2;

  localparam logic [MULT_W-1:0] MULT_ONE = MULT_W'(256);

  typedef enum logic [1:0] {
    OP_LOAD_ATT = 2'd0,
    OP_LOAD_RET = 2'd1,
    OP_RESTART  = 2'd2,
    OP_NEXT     = 2'd3
  } op_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_ATT_MULT = 3'd0,
    REG_RET_MULT = 3'd1,
    REG_ATT_MAX  = 3'd2,
    REG_RET_MAX  = 3'd3,
    REG_ATT_LEN  = 3'd4,
    REG_RET_LEN  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] entry_index;
    logic [DUR_W-1:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [DUR_W-1:0] attempt_timeout;
    logic [DUR_W-1:0] retry_delay;
    logic [CNT_W-1:0] attempt_count;
  } out_item_t;

  // How a track forms its new value in the compute stage.
  typedef struct packed {
    logic take_tab;  // take the table word just read, then clamp
    logic grow;      // scale the current value, saturate, then clamp
  } track_sel_t;

endpackage

[rtl/bts_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module bts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/bts_track.sv]
// One back-off track: duration table in RAM, current value and its update.
// Depends on bts_pkg and bts_ram.
module bts_track #(
  parameter int TABLE_DEPTH = bts_pkg::TABLE_DEPTH_DEF,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       tab_we,
  input  logic [AW-1:0]              tab_waddr,
  input  logic [bts_pkg::DUR_W-1:0]  tab_wdata,
  input  logic                       tab_re,
  input  logic [AW-1:0]              tab_raddr,
  input  bts_pkg::track_sel_t        sel,
  input  logic                       upd,
  input  logic [bts_pkg::MULT_W-1:0] mult,
  input  logic [bts_pkg::DUR_W-1:0]  maxv,
  output logic [bts_pkg::DUR_W-1:0]  value
);
  import bts_pkg::*;

  localparam int PROD_W = DUR_W + MULT_W;

  logic [DUR_W-1:0]  cur_r;
  logic [DUR_W-1:0]  cur_nxt;
  logic [DUR_W-1:0]  rdata;
  logic [PROD_W-1:0] prod;
  logic [DUR_W-1:0]  grown;
  logic [DUR_W-1:0]  raw;
  logic [DUR_W-1:0]  clamped;

  bts_ram #(
    .WIDTH(DUR_W),
    .DEPTH(TABLE_DEPTH)
  ) u_tab (
    .clk  (clk),
    .we   (tab_we),
    .waddr(tab_waddr),
    .wdata(tab_wdata),
    .re   (tab_re),
    .raddr(tab_raddr),
    .rdata(rdata)
  );

  // Q8.8 scaling: drop the eight fraction bits, saturate what is left.
  always_comb begin
    prod    = PROD_W'(cur_r) * PROD_W'(mult);
    grown   = (|prod[PROD_W-1:DUR_W+8]) ? '1 : prod[DUR_W+7:8];
    raw     = sel.take_tab ? rdata : grown;
    clamped = ((maxv != '0) && (raw > maxv)) ? maxv : raw;
    cur_nxt = (sel.take_tab || sel.grow) ? clamped : cur_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
    end else if (upd) begin
      cur_r <= cur_nxt;
    end
  end

  assign value = cur_nxt;

endmodule

[rtl/bts_outq.sv]
// Three-entry result queue between the compute stage and the output port.
// Depends on bts_pkg.
module bts_outq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  bts_pkg::out_item_t           push_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output bts_pkg::out_item_t           out_data,
  output logic [bts_pkg::OUTQ_PW-1:0]  level
);
  import bts_pkg::*;

  localparam logic [OUTQ_PW-1:0] LAST = OUTQ_PW'(OUTQ_DEPTH - 1);

  out_item_t          q_r [OUTQ_DEPTH];
  logic [OUTQ_PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OUTQ_PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OUTQ_PW-1:0] level_r, level_nxt;
  logic               pop;

  assign out_valid = (level_r != '0);
  assign out_data  = q_r[rd_ptr_r];
  assign level     = level_r;
  assign pop       = out_valid && !out_stall;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      level_nxt = level_r + 1'b1;
    end else if (pop && !push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/backoff_timeout_sequencer.sv]
// Top level of the back-off timeout sequencer: issue stage, two tracks, result queue.
// Depends on bts_pkg, bts_track, bts_outq and assert_macros.svh.
//
//  port group   direction  beat carries
//  in_*         in         op, entry_index, entry_value
//  out_*        out        attempt_timeout, retry_delay, attempt_count
//  cfg_*        in         register index and write data, one write per cycle
//
// One item per cycle sustained while out_stall stays low. An accepted item reads
// its table word in the cycle of acceptance; the next cycle forms both new durations
// (one 32x16 multiply and a clamp per track) and pushes the result into a
// three-entry queue, which holds the result beat before it is offered on out_*.
// Reset is synchronous; tables are not cleared and need loading.
// in_stall is high in reset, when the queue holds three beats, and when it holds
// two while the compute stage is still busy.
`include "assert_macros.svh"

module backoff_timeout_sequencer #(
  parameter int TABLE_DEPTH = bts_pkg::TABLE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  bts_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output bts_pkg::out_item_t           out_data,
  input  logic                         cfg_we,
  input  logic [bts_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [bts_pkg::CFG_DW-1:0]   cfg_wdata
);
  import bts_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [LEN_W-1:0] DEPTH_CAP =
    (TABLE_DEPTH < (1 << LEN_W)) ? LEN_W'(TABLE_DEPTH) : '1;

  // Configuration registers.
  logic [MULT_W-1:0] att_mult_r, ret_mult_r;
  logic [DUR_W-1:0]  att_max_r, ret_max_r;
  logic [LEN_W-1:0]  att_len_r, ret_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      att_mult_r <= MULT_ONE;
      ret_mult_r <= MULT_ONE;
      att_max_r  <= '0;
      ret_max_r  <= '0;
      att_len_r  <= '0;
      ret_len_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ATT_MULT: att_mult_r <= cfg_wdata[MULT_W-1:0];
        REG_RET_MULT: ret_mult_r <= cfg_wdata[MULT_W-1:0];
        REG_ATT_MAX:  att_max_r  <= cfg_wdata[DUR_W-1:0];
        REG_RET_MAX:  ret_max_r  <= cfg_wdata[DUR_W-1:0];
        REG_ATT_LEN:  att_len_r  <= cfg_wdata[LEN_W-1:0];
        REG_RET_LEN:  ret_len_r  <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Issue stage: count update, table write or read.
  logic              accept;
  logic              is_next, is_rst, idx_ok;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [LEN_W-1:0]  att_eff, ret_eff;
  track_sel_t        att_sel_nxt, ret_sel_nxt;
  logic              tab_re;
  logic [AW-1:0]     tab_raddr, tab_waddr;
  logic              att_we, ret_we;

  logic              s1_valid_r, s1_valid_nxt;
  logic [CNT_W-1:0]  s1_cnt_r;
  track_sel_t        s1_att_sel_r, s1_ret_sel_r;
  logic              s1_push;
  logic [OUTQ_PW-1:0] q_level;

  assign accept  = in_valid && !in_stall;
  assign is_next = (in_data.op == OP_NEXT);
  assign is_rst  = (in_data.op == OP_RESTART);
  assign idx_ok  = (32'(in_data.entry_index) < 32'(TABLE_DEPTH));

  always_comb begin
    att_eff = (att_len_r < DEPTH_CAP) ? att_len_r : DEPTH_CAP;
    ret_eff = (ret_len_r < DEPTH_CAP) ? ret_len_r : DEPTH_CAP;

    unique case (in_data.op)
      OP_RESTART: cnt_nxt = '0;
      OP_NEXT:    cnt_nxt = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;
      default:    cnt_nxt = cnt_r;
    endcase

    att_sel_nxt.take_tab = (is_rst && (att_eff != '0)) ||
                           (is_next && (CNT_W'(att_eff) > cnt_nxt));
    att_sel_nxt.grow     = is_next && !(CNT_W'(att_eff) > cnt_nxt);
    ret_sel_nxt.take_tab = (is_rst && (ret_eff != '0)) ||
                           (is_next && (CNT_W'(ret_eff) > cnt_nxt));
    ret_sel_nxt.grow     = is_next && !(CNT_W'(ret_eff) > cnt_nxt);

    tab_re    = accept && (is_rst || is_next);
    tab_raddr = is_next ? AW'(cnt_nxt) : '0;
    tab_waddr = AW'(in_data.entry_index);
    att_we    = accept && (in_data.op == OP_LOAD_ATT) && idx_ok;
    ret_we    = accept && (in_data.op == OP_LOAD_RET) && idx_ok;
  end

  // The compute stage always drains into the queue whenever a new item is
  // admitted, so its table read data never has to be held across a new read.
  assign in_stall = !rst_n || (q_level == OUTQ_PW'(OUTQ_DEPTH)) ||
                    ((q_level == OUTQ_PW'(OUTQ_DEPTH - 1)) && s1_valid_r);
  assign s1_push      = s1_valid_r && (q_level != OUTQ_PW'(OUTQ_DEPTH));
  assign s1_valid_nxt = accept ? 1'b1 : (s1_valid_r && !s1_push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cnt_r     <= cnt_nxt;
      s1_att_sel_r <= att_sel_nxt;
      s1_ret_sel_r <= ret_sel_nxt;
    end
  end

  // Compute stage: both tracks.
  logic [DUR_W-1:0] att_value, ret_value;
  out_item_t        res;

  bts_track #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_att (
    .clk      (clk),
    .rst_n    (rst_n),
    .tab_we   (att_we),
    .tab_waddr(tab_waddr),
    .tab_wdata(in_data.entry_value),
    .tab_re   (tab_re),
    .tab_raddr(tab_raddr),
    .sel      (s1_att_sel_r),
    .upd      (s1_push),
    .mult     (att_mult_r),
    .maxv     (att_max_r),
    .value    (att_value)
  );

  bts_track #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ret (
    .clk      (clk),
    .rst_n    (rst_n),
    .tab_we   (ret_we),
    .tab_waddr(tab_waddr),
    .tab_wdata(in_data.entry_value),
    .tab_re   (tab_re),
    .tab_raddr(tab_raddr),
    .sel      (s1_ret_sel_r),
    .upd      (s1_push),
    .mult     (ret_mult_r),
    .maxv     (ret_max_r),
    .value    (ret_value)
  );

  always_comb begin
    res.attempt_timeout = att_value;
    res.retry_delay     = ret_value;
    res.attempt_count   = s1_cnt_r;
  end

  bts_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (s1_push),
    .push_data(res),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .level    (q_level)
  );

  `ASSERT_NEVER(a_s1_overrun, clk, rst_n,
    accept && s1_valid_r && !s1_push, "compute stage overwritten")
  `ASSERT_CLK(a_restart_clears, clk, rst_n,
    (accept && is_rst) |=> (cnt_r == '0), "restart did not clear count")
  `ASSERT_CLK(a_next_counts, clk, rst_n,
    (accept && is_next && (cnt_r != '1)) |=> (cnt_r == CNT_W'($past(cnt_r) + 1'b1)),
    "count did not advance")
  `ASSERT_NEVER(a_tab_rw_clash, clk, rst_n,
    tab_re && (att_we || ret_we), "table read and write in one cycle")

endmodule

[tb/tb_backoff_timeout_sequencer.sv]
// Self-checking testbench for backoff_timeout_sequencer: directed table walks, random
// restart/next-attempt sequences and a growth-to-clamp run, checked against a shadow copy.
// Depends on bts_pkg and the backoff_timeout_sequencer RTL.
module tb_backoff_timeout_sequencer;
  import bts_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int TRAFFIC_PHASES = 7;
  localparam int PHASE_ITEMS = 100;
  localparam int GROWTH_NEXTS = 40;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_TOGGLE
  } rx_mode_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_we = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr = '0;
  logic [CFG_DW-1:0]   cfg_wdata = '0;

  // Shadow copy of the registers and state of the sequencer.
  logic [MULT_W-1:0]   sh_att_mult = MULT_ONE;
  logic [MULT_W-1:0]   sh_ret_mult = MULT_ONE;
  logic [DUR_W-1:0]    sh_att_max = '0;
  logic [DUR_W-1:0]    sh_ret_max = '0;
  logic [LEN_W-1:0]    sh_att_len = '0;
  logic [LEN_W-1:0]    sh_ret_len = '0;
  logic [DUR_W-1:0]    sh_att_tab [TABLE_DEPTH_DEF];
  logic [DUR_W-1:0]    sh_ret_tab [TABLE_DEPTH_DEF];
  logic [DUR_W-1:0]    sh_cur_att = '0;
  logic [DUR_W-1:0]    sh_cur_ret = '0;
  logic [CNT_W-1:0]    sh_count = '0;

  out_item_t           durations_due [$];
  out_item_t           oldest_due;
  int                  errors = 0;
  int                  burst_left = 1;
  int                  quiet_cycles = 0;
  rx_mode_t            rx_mode = RX_FREE;
  int                  rx_span = 0;

  backoff_timeout_sequencer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic logic [DUR_W-1:0] clamp_duration(logic [DUR_W-1:0] v,
                                                      logic [DUR_W-1:0] maxv);
    return (maxv != '0 && v > maxv) ? maxv : v;
  endfunction

  // Table entry while the count is inside the table, otherwise the scaled and
  // saturated current value; the clamp applies to both.
  function automatic logic [DUR_W-1:0] next_duration(logic [DUR_W-1:0] cur,
                                                     logic [DUR_W-1:0] tab_word,
                                                     logic [LEN_W-1:0] len,
                                                     logic [MULT_W-1:0] mult,
                                                     logic [DUR_W-1:0] maxv,
                                                     logic [CNT_W-1:0] count);
    logic [63:0]      prod;
    logic [DUR_W-1:0] v;
    int               eff_len;
    eff_len = (len > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(len);
    if (int'(count) < eff_len) begin
      v = tab_word;
    end else begin
      prod = (64'(cur) * 64'(mult)) >> 8;
      v = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[DUR_W-1:0];
    end
    return clamp_duration(v, maxv);
  endfunction

  // Applies one accepted beat to the shadow state and returns the durations it yields.
  function automatic out_item_t apply_item(in_item_t it);
    out_item_t r;
    case (it.op)
      OP_LOAD_ATT: sh_att_tab[it.entry_index] = it.entry_value;
      OP_LOAD_RET: sh_ret_tab[it.entry_index] = it.entry_value;
      OP_RESTART: begin
        sh_count = '0;
        if (sh_att_len != '0) sh_cur_att = clamp_duration(sh_att_tab[0], sh_att_max);
        if (sh_ret_len != '0) sh_cur_ret = clamp_duration(sh_ret_tab[0], sh_ret_max);
      end
      OP_NEXT: begin
        if (sh_count != 16'hFFFF) sh_count = sh_count + 16'd1;
        sh_cur_att = next_duration(sh_cur_att, sh_att_tab[sh_count[IDX_W-1:0]], sh_att_len,
                                   sh_att_mult, sh_att_max, sh_count);
        sh_cur_ret = next_duration(sh_cur_ret, sh_ret_tab[sh_count[IDX_W-1:0]], sh_ret_len,
                                   sh_ret_mult, sh_ret_max, sh_count);
      end
      default: ;
    endcase
    r.attempt_timeout = sh_cur_att;
    r.retry_delay = sh_cur_ret;
    r.attempt_count = sh_count;
    return r;
  endfunction

  function automatic logic [DUR_W-1:0] rand_duration();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1, 1000);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t make_item(op_t op);
    in_item_t it;
    it.op = op;
    it.entry_index = IDX_W'($urandom_range(0, TABLE_DEPTH_DEF - 1));
    it.entry_value = rand_duration();
    return it;
  endfunction

  function automatic void check_field(string name, logic [DUR_W-1:0] want,
                                      logic [DUR_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Sender: holds the beat until it is taken, then either carries on with the burst
  // or drops valid for a random gap.
  task automatic send_item(input in_item_t it);
    int        gap;
    out_item_t due;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    due = apply_item(it);
    durations_due.insert(durations_due.size(), due);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Waits until every outstanding result has been taken, then lets the pipeline settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (durations_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t r, input logic [CFG_DW-1:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= r;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  task automatic program_registers(input logic [MULT_W-1:0] att_mult,
                                   input logic [MULT_W-1:0] ret_mult,
                                   input logic [DUR_W-1:0] att_max,
                                   input logic [DUR_W-1:0] ret_max,
                                   input logic [LEN_W-1:0] att_len,
                                   input logic [LEN_W-1:0] ret_len);
    write_reg(REG_ATT_MULT, CFG_DW'(att_mult));
    write_reg(REG_RET_MULT, CFG_DW'(ret_mult));
    write_reg(REG_ATT_MAX, att_max);
    write_reg(REG_RET_MAX, ret_max);
    write_reg(REG_ATT_LEN, CFG_DW'(att_len));
    write_reg(REG_RET_LEN, CFG_DW'(ret_len));
    cfg_we <= 1'b0;
    sh_att_mult = att_mult;
    sh_ret_mult = ret_mult;
    sh_att_max = att_max;
    sh_ret_max = ret_max;
    sh_att_len = att_len;
    sh_ret_len = ret_len;
    @(posedge clk);
  endtask

  // Every entry of both tables is written here, so no later read finds an unwritten one.
  task automatic test_table_loads();
    in_item_t it;
    for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
      it = make_item(OP_LOAD_ATT);
      it.entry_index = IDX_W'(i);
      if (i == 0) it.entry_value = 32'hFFFF_FFFF;
      else if (i == TABLE_DEPTH_DEF - 1) it.entry_value = '0;
      send_item(it);
      it = make_item(OP_LOAD_RET);
      it.entry_index = IDX_W'(i);
      if (i == 0) it.entry_value = 32'hFFFF_FFFF;
      send_item(it);
    end
  endtask

  // Walks the attempt table with a length beyond the depth, overflows the retry
  // product, clamps at restart and finally restarts with both tables empty.
  task automatic test_table_walk();
    drain_results();
    program_registers(16'd0, 16'hFFFF, '0, '0, 4'd15, 4'd1);
    send_item(make_item(OP_RESTART));
    repeat (TABLE_DEPTH_DEF) send_item(make_item(OP_NEXT));
    drain_results();
    program_registers(16'd384, 16'd200, 32'd12345, 32'd1000, 4'd2, 4'd3);
    send_item(make_item(OP_RESTART));
    repeat (2) send_item(make_item(OP_NEXT));
    drain_results();
    // Empty tables: the restart keeps the current values even above the new maxima.
    program_registers(16'd256, 16'd256, 32'd100, 32'd10, 4'd0, 4'd0);
    send_item(make_item(OP_RESTART));
  endtask

  task automatic test_random_traffic();
    logic [MULT_W-1:0] mults [2];
    logic [DUR_W-1:0]  maxes [2];
    logic [LEN_W-1:0]  lens [2];
    int                sent;
    int                run;
    bit                paused;
    for (int p = 0; p < TRAFFIC_PHASES; p++) begin
      for (int t = 0; t < 2; t++) begin
        if (p == 0) begin
          mults[t] = 16'hFFFF;
          maxes[t] = 32'hFFFF_FFFF;
          lens[t] = 4'd15;
        end else if (p == 1) begin
          mults[t] = '0;
          maxes[t] = '0;
          lens[t] = '0;
        end else begin
          case ($urandom_range(0, 4))
            0: mults[t] = '0;
            1: mults[t] = MULT_ONE;
            2: mults[t] = 16'hFFFF;
            3: mults[t] = MULT_W'($urandom_range(256, 1024));
            default: mults[t] = MULT_W'($urandom);
          endcase
          case ($urandom_range(0, 3))
            0: maxes[t] = '0;
            1: maxes[t] = 32'hFFFF_FFFF;
            2: maxes[t] = $urandom_range(1, 100000);
            default: maxes[t] = $urandom;
          endcase
          lens[t] = LEN_W'($urandom_range(0, 15));
        end
      end
      drain_results();
      program_registers(mults[0], mults[1], maxes[0], maxes[1], lens[0], lens[1]);
      sent = 0;
      paused = 1'b0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 8) begin
          send_item(make_item(OP_RESTART));
          sent++;
          run = $urandom_range(0, 20);
          repeat (run) begin
            if ($urandom_range(0, 9) == 0) send_item(make_item(op_t'($urandom_range(0, 1))));
            else send_item(make_item(OP_NEXT));
            sent++;
          end
        end else begin
          run = $urandom_range(1, 4);
          repeat (run) begin
            send_item(make_item(op_t'($urandom_range(0, 3))));
            sent++;
          end
        end
        if (!paused && sent >= PHASE_ITEMS / 2) begin
          drain_results();
          paused = 1'b1;
        end
      end
    end
  endtask

  // A long run of attempts past the table so that growth reaches the clamp.
  task automatic test_growth_to_clamp();
    drain_results();
    program_registers(16'd384, MULT_ONE, 32'd5000000, '0, 4'd2, 4'd3);
    send_item(make_item(OP_RESTART));
    repeat (GROWTH_NEXTS) send_item(make_item(OP_NEXT));
    send_item(make_item(OP_RESTART));
    send_item(make_item(OP_NEXT));
  endtask

  // Receiver stalls follow a mode that is redrawn after a random span.
  always @(posedge clk) begin
    if (rx_span == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_span <= $urandom_range(20, 120);
    end else begin
      rx_span <= rx_span - 1;
    end
    case (rx_mode)
      RX_FREE:  out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(0, 7) == 0);
      RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:  out_stall <= ~out_stall;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (durations_due.size() == 0) begin
        $display("%0t: result beat with none outstanding: actual %h", $time, out_data);
        errors++;
      end else begin
        oldest_due = durations_due.pop_front();
        check_field("attempt_timeout", oldest_due.attempt_timeout, out_data.attempt_timeout);
        check_field("retry_delay", oldest_due.retry_delay, out_data.retry_delay);
        check_field("attempt_count", DUR_W'(oldest_due.attempt_count),
                    DUR_W'(out_data.attempt_count));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_table_loads();
    test_table_walk();
    test_random_traffic();
    test_growth_to_clamp();
    drain_results();
    repeat (8) @(posedge clk);
    if (durations_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, durations_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
